// ----- src/assert_macros.svh -----
// Assertion macros shared by the RTL files of the culling core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while the block is out of reset.
`define SFC_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Checked at every edge, reset included.
`define SFC_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- src/sfcl_pkg.sv -----
// Shared types, constants and field helpers of the culling core.
package sfcl_pkg;

    localparam int NUM_PLANES   = 6;
    localparam int POS_W        = 20;
    localparam int RAD_W        = 16;
    localparam int NRM_W        = 14;
    localparam int OFF_W        = 22;
    localparam int DIFF_W       = POS_W + 1;
    localparam int SQR_W        = 2 * POS_W;
    localparam int SUM_W        = SQR_W + 2;
    localparam int DIST_W       = 21;
    localparam int PROD_W       = NRM_W + POS_W;
    localparam int DOT_W        = PROD_W + 4;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 64;
    localparam int CAM_W        = 3 * POS_W;
    localparam int IN_TDATA_W   = 96;
    localparam int OUT_TDATA_W  = 24;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_LEFT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RIGHT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TOP    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BOTTOM = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_NEAR   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FAR    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_CAMERA = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_HTOP   = 3'd7;

    localparam int PLANE_TOP    = 2;
    localparam int PLANE_BOTTOM = 3;

    // Level of detail codes.
    localparam logic [1:0] LOD_NEAR = 2'd0;
    localparam logic [1:0] LOD_MID  = 2'd1;
    localparam logic [1:0] LOD_FAR  = 2'd2;

    // Squared thresholds in Q.4: 100, 500 and 1000 units.
    localparam logic [SUM_W-1:0] NEAR_SQ = SUM_W'(64'd2560000);
    localparam logic [SUM_W-1:0] LOD0_SQ = SUM_W'(64'd64000000);
    localparam logic [SUM_W-1:0] LOD1_SQ = SUM_W'(64'd256000000);

    typedef struct packed {
        logic       active;
        logic [1:0] lod;
    } side_t;

    function automatic logic signed [NRM_W-1:0] plane_normal(
        input logic [CFG_DATA_W-1:0] pl, input int axis);
        return $signed(pl[axis*NRM_W +: NRM_W]);
    endfunction

    function automatic logic signed [OFF_W-1:0] plane_offset(
        input logic [CFG_DATA_W-1:0] pl);
        return $signed(pl[CFG_DATA_W-1 -: OFF_W]);
    endfunction

endpackage

// ----- src/sfcl_sqrt_pipe.sv -----
// Pipelined integer square root, one result bit per stage, with sideband.
`include "assert_macros.svh"

module sfcl_sqrt_pipe #(
    parameter int IN_W   = sfcl_pkg::SUM_W,
    parameter int SIDE_W = $bits(sfcl_pkg::side_t)
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    en,
    input  logic                    in_valid,
    input  logic [SIDE_W-1:0]       in_side,
    input  logic [IN_W-1:0]         in_x,
    output logic                    out_valid,
    output logic [SIDE_W-1:0]       out_side,
    output logic [(IN_W+1)/2-1:0]   out_root
);

    localparam int N   = (IN_W + 1) / 2;
    localparam int R_W = IN_W + 1;

    logic [IN_W-1:0]   x_reg    [N];
    logic [R_W-1:0]    res_reg  [N];
    logic [SIDE_W-1:0] side_reg [N];
    logic [N-1:0]      v_reg;
    logic [IN_W-1:0]   x_next   [N];
    logic [R_W-1:0]    res_next [N];

    // Each stage tries the next lower root bit against the remaining radicand.
    always_comb begin
        logic [IN_W-1:0] x_in;
        logic [R_W-1:0]  res_in;
        logic [R_W-1:0]  bit_val;
        logic [R_W-1:0]  trial;
        for (int s = 0; s < N; s++) begin
            if (s == 0) begin
                x_in   = in_x;
                res_in = '0;
            end else begin
                x_in   = x_reg[s-1];
                res_in = res_reg[s-1];
            end
            bit_val = R_W'(1) << (2 * (N - 1 - s));
            trial   = res_in + bit_val;
            if ({1'b0, x_in} >= trial) begin
                x_next[s]   = x_in - trial[IN_W-1:0];
                res_next[s] = (res_in >> 1) + bit_val;
            end else begin
                x_next[s]   = x_in;
                res_next[s] = res_in >> 1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[N-2:0], in_valid};
        end
        if (en) begin
            side_reg[0] <= in_side;
            for (int s = 0; s < N; s++) begin
                x_reg[s]   <= x_next[s];
                res_reg[s] <= res_next[s];
            end
            for (int s = 1; s < N; s++) begin
                side_reg[s] <= side_reg[s-1];
            end
        end
    end

    assign out_valid = v_reg[N-1];
    assign out_side  = side_reg[N-1];
    assign out_root  = res_reg[N-1][N-1:0];

    // The final remainder never reaches twice the root plus one.
    `SFC_ASSERT(a_rem_bound, aclk, aresetn,
        out_valid |-> ({1'b0, x_reg[N-1]} <= (res_reg[N-1] << 1)), "sqrt remainder too large")
    `SFC_ASSERT(a_root_range, aclk, aresetn,
        out_valid |-> (res_reg[N-1] >> N) == '0, "sqrt root overflow")

endmodule

// ----- src/sphere_frustum_cull_lod_core.sv -----
// Top level of the bounding-sphere frustum culling and level-of-detail core.
// Usage: software writes six packed frustum planes, the camera position and the
// height mode through the cfg_* write port while the core is idle. Objects then
// stream in on the s_axis-style channel, one word per object, and one result
// word per object leaves on the m_ channel in the same order.
// From input acceptance to m_tvalid a word passes three arithmetic
// stages (differences and plane products, squares and plane sums, squared
// distance and threshold compares) followed by a 21-stage square root that
// resolves one distance bit per stage. Throughput is one word per cycle while
// the receiver keeps up; the root pipeline depth sets the latency, not the rate.
// All stages advance together whenever the output register is empty or is
// being taken, so s_tready is low only while a result waits on a stalled
// receiver. A stall freezes every stage; nothing is dropped or repeated.
// Reset (aresetn low, synchronous) clears all valid bits and all
// configuration registers; zero planes pass any object with nonzero radius.
// The distance output cannot exceed 21 bits for 20-bit coordinates, so the
// floored root fits the field without clamping.
`include "assert_macros.svh"

module sphere_frustum_cull_lod_core (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // cfg port
    input  logic                                 cfg_wr_en,
    input  logic [sfcl_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [sfcl_pkg::CFG_DATA_W-1:0]      cfg_data,
    // input words
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // low to high: pos_x[19:0], pos_y[39:20], pos_z[59:40], radius[75:60],
    // max_height[91:76], zero fill [95:92]
    input  logic [sfcl_pkg::IN_TDATA_W-1:0]      s_tdata,
    // result words
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // low to high: active[0], lod[2:1], distance[23:3]
    output logic [sfcl_pkg::OUT_TDATA_W-1:0]     m_tdata
);

    localparam int NP   = sfcl_pkg::NUM_PLANES;
    localparam int PW   = sfcl_pkg::POS_W;
    localparam int RW   = sfcl_pkg::RAD_W;
    localparam int DW   = sfcl_pkg::DIFF_W;
    localparam int PRW  = sfcl_pkg::PROD_W;
    localparam int DOTW = sfcl_pkg::DOT_W;

    // Configuration registers.
    logic [sfcl_pkg::CFG_DATA_W-1:0] plane_reg [NP];
    logic [sfcl_pkg::CAM_W-1:0]      cam_reg;
    logic                            htop_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NP; i++) plane_reg[i] <= '0;
            cam_reg  <= '0;
            htop_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                sfcl_pkg::REG_LEFT:   plane_reg[0] <= cfg_data;
                sfcl_pkg::REG_RIGHT:  plane_reg[1] <= cfg_data;
                sfcl_pkg::REG_TOP:    plane_reg[2] <= cfg_data;
                sfcl_pkg::REG_BOTTOM: plane_reg[3] <= cfg_data;
                sfcl_pkg::REG_NEAR:   plane_reg[4] <= cfg_data;
                sfcl_pkg::REG_FAR:    plane_reg[5] <= cfg_data;
                sfcl_pkg::REG_CAMERA: cam_reg      <= cfg_data[sfcl_pkg::CAM_W-1:0];
                sfcl_pkg::REG_HTOP:   htop_reg     <= cfg_data[0];
                default:              ;
            endcase
        end
    end

    // Global advance: the last root stage is the output register.
    logic en;
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    // Input fields.
    logic signed [PW-1:0] pos [3];
    logic signed [PW-1:0] cam [3];
    logic [RW-1:0]        in_radius;
    logic [RW-1:0]        in_height;

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            pos[a] = $signed(s_tdata[a*PW +: PW]);
            cam[a] = $signed(cam_reg[a*PW +: PW]);
        end
    end
    assign in_radius = s_tdata[3*PW +: RW];
    assign in_height = s_tdata[3*PW+RW +: RW];

    // Stage 1: camera differences and plane products.
    logic                  v1_reg;
    logic signed [DW-1:0]  diff_reg [3];
    logic signed [PRW-1:0] prod_reg [NP][3];
    logic [RW-1:0]         rad1_reg;
    logic [RW-1:0]         hgt1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_tvalid;
        end
        if (en) begin
            for (int a = 0; a < 3; a++) begin
                diff_reg[a] <= DW'(cam[a]) - DW'(pos[a]);
                for (int p = 0; p < NP; p++) begin
                    prod_reg[p][a] <= PRW'(sfcl_pkg::plane_normal(plane_reg[p], a)) * PRW'(pos[a]);
                end
            end
            rad1_reg <= in_radius;
            hgt1_reg <= in_height;
        end
    end

    // Stage 2: squares and per-plane sums.
    logic                            v2_reg;
    logic [sfcl_pkg::SQR_W-1:0]      sqr_reg [3];
    logic [NP-1:0]                   pass_reg;
    logic                            rzero2_reg;
    logic [NP-1:0]                   pass_next;

    always_comb begin
        logic signed [DOTW-1:0] dot;
        logic [RW:0]            slack;
        for (int p = 0; p < NP; p++) begin
            slack = {1'b0, rad1_reg};
            if ((p == sfcl_pkg::PLANE_TOP && htop_reg) ||
                (p == sfcl_pkg::PLANE_BOTTOM && !htop_reg)) begin
                slack = slack + {1'b0, hgt1_reg};
            end
            // The offset is signed, so it is sign-extended after the shift.
            dot = DOTW'(prod_reg[p][0]) + DOTW'(prod_reg[p][1]) + DOTW'(prod_reg[p][2])
                + $signed(DOTW'({slack, 12'b0}))
                + DOTW'($signed({sfcl_pkg::plane_offset(plane_reg[p]), 12'b0}));
            pass_next[p] = (dot > 0);
        end
    end

    always_ff @(posedge aclk) begin
        logic signed [2*DW-1:0] sq;
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en) begin
            v2_reg <= v1_reg;
        end
        if (en) begin
            for (int a = 0; a < 3; a++) begin
                sq = diff_reg[a] * diff_reg[a];
                sqr_reg[a] <= sq[sfcl_pkg::SQR_W-1:0];
            end
            pass_reg   <= pass_next;
            rzero2_reg <= (rad1_reg == '0);
        end
    end

    // Stage 3: squared distance and threshold compares.
    logic                       v3_reg;
    logic [sfcl_pkg::SUM_W-1:0] sum_reg;
    logic                       near3_reg;
    logic                       lt0_reg;
    logic                       lt1_reg;
    logic                       inside3_reg;
    logic                       rzero3_reg;
    logic [sfcl_pkg::SUM_W-1:0] sum_next;

    assign sum_next = sfcl_pkg::SUM_W'(sqr_reg[0]) + sfcl_pkg::SUM_W'(sqr_reg[1])
                    + sfcl_pkg::SUM_W'(sqr_reg[2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (en) begin
            v3_reg <= v2_reg;
        end
        if (en) begin
            sum_reg     <= sum_next;
            near3_reg   <= (sum_next < sfcl_pkg::NEAR_SQ);
            lt0_reg     <= (sum_next < sfcl_pkg::LOD0_SQ);
            lt1_reg     <= (sum_next < sfcl_pkg::LOD1_SQ);
            inside3_reg <= &pass_reg;
            rzero3_reg  <= rzero2_reg;
        end
    end

    // Decision travels beside the root as sideband.
    sfcl_pkg::side_t side_in;
    sfcl_pkg::side_t side_out;
    logic [sfcl_pkg::DIST_W-1:0] root_dist;
    logic                        root_valid;

    always_comb begin
        side_in.active = rzero3_reg || inside3_reg || near3_reg;
        if (!side_in.active || lt0_reg) begin
            side_in.lod = sfcl_pkg::LOD_NEAR;
        end else if (lt1_reg) begin
            side_in.lod = sfcl_pkg::LOD_MID;
        end else begin
            side_in.lod = sfcl_pkg::LOD_FAR;
        end
    end

    sfcl_sqrt_pipe #(
        .IN_W   (sfcl_pkg::SUM_W),
        .SIDE_W ($bits(sfcl_pkg::side_t))
    ) u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v3_reg),
        .in_side   (side_in),
        .in_x      (sum_reg),
        .out_valid (root_valid),
        .out_side  (side_out),
        .out_root  (root_dist)
    );

    assign m_tvalid = root_valid;
    assign m_tdata  = {root_dist, side_out.lod, side_out.active};

    `SFC_ASSERT(a_lod_code, aclk, aresetn,
        m_tvalid |-> (side_out.lod != 2'd3), "invalid level of detail code")
    `SFC_ASSERT(a_culled_lod, aclk, aresetn,
        m_tvalid && !side_out.active |-> side_out.lod == sfcl_pkg::LOD_NEAR,
        "culled object with nonzero level of detail")
    `SFC_ASSERT_ALWAYS(a_reset_empty, aclk,
        !aresetn |=> !m_tvalid && !v1_reg && !v3_reg, "pipeline not empty after reset")

endmodule
